/* hw/rtl/http_response_header_parser_assert.svh */
// Assertion macros for the HTTP response header parser.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef HTTP_RESPONSE_HEADER_PARSER_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled at the rising edge, off during reset
`define HRHP_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled at the rising edge, off during reset
`define HRHP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HRHP_CHECK_NOW(lbl, ante, cons, msg)
`define HRHP_CHECK_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/hrhp_pkg.sv */
// Shared types and constants for the HTTP response header parser.
// No dependencies; imported by every module of the block.
package hrhp_pkg;

  localparam int LEN_W  = 31;
  localparam int CODE_W = 10;
  localparam int TL_W   = 5;

  localparam logic [LEN_W-1:0]  LEN_MAX      = 31'h7FFF_FFFF;
  localparam logic [LEN_W-1:0]  RESET_LENGTH = 31'd1000000000;
  localparam logic [CODE_W-1:0] CODE_MAX     = 10'd999;
  localparam logic [9:0]        CODE_OK      = 10'd200;

  // Token lengths that matter
  localparam logic [TL_W-1:0] HTTP_TAG_LEN = 5'd5;
  localparam logic [TL_W-1:0] CLEN_TAG_LEN = 5'd15;
  localparam logic [TL_W-1:0] CODE_LEN     = 5'd3;
  localparam logic [TL_W-1:0] TL_MAX       = 5'd31;

  // Tag strings, compared one character per byte
  localparam logic [7:0] TAG_HTTP [5] = '{"H", "T", "T", "P", "/"};
  localparam logic [7:0] TAG_CLEN [15] = '{"C", "o", "n", "t", "e", "n", "t", "-",
                                           "L", "e", "n", "g", "t", "h", ":"};

  typedef enum logic [1:0] {
    MODE_DATA  = 2'd0,
    MODE_CLOSE = 2'd1,
    MODE_START = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_ACCEPT   = 3'd1,
    KIND_PAYLOAD  = 3'd2,
    KIND_FINISHED = 3'd3,
    KIND_REJECT   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // One classified input item as it travels through the queue
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
    logic       is_cr;
    logic       is_lf;
    logic       is_sp;
    logic       is_nul;
    logic       is_digit;
    logic [3:0] digit;
  } item_t;

endpackage

/* hw/rtl/hrhp_front.sv */
// Front end: classifies each incoming byte for the parser back end.
// Depends on hrhp_pkg (item_t).
module hrhp_front import hrhp_pkg::*; (
  input  logic [1:0] in_mode,
  input  logic [7:0] in_data_byte,
  output item_t      item
);

  logic [7:0] diff;

  assign diff = in_data_byte - 8'h30;

  // Delimiter and digit flags
  always_comb begin
    item.mode     = in_mode;
    item.data     = in_data_byte;
    item.is_cr    = (in_data_byte == 8'h0D);
    item.is_lf    = (in_data_byte == 8'h0A);
    item.is_sp    = (in_data_byte == 8'h20);
    item.is_nul   = (in_data_byte == 8'h00);
    item.is_digit = (in_data_byte >= 8'h30) && (in_data_byte <= 8'h39);
    item.digit    = diff[3:0];
  end

endmodule

/* hw/rtl/hrhp_fifo.sv */
// Short queue of classified items between front and back end.
// Depends on hrhp_pkg (item_t).
module hrhp_fifo import hrhp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  full,
  output logic  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/hrhp_back.sv */
// Back end: header/body FSM, registered result, one item per unstalled cycle.
// Depends on hrhp_pkg (item_t, phase_t, kind_t, tags and limits).
module hrhp_back import hrhp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  item_t             item,
  output logic              pop,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_default_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [7:0]        out_payload_byte,
  output logic [CODE_W-1:0] out_status_code
);

  phase_t            phase_r, phase_nxt;
  logic [1:0]        crlf_r, crlf_nxt;
  logic              exp_code_r, exp_code_nxt;
  logic              exp_msg_r, exp_msg_nxt;
  logic              exp_len_r, exp_len_nxt;
  logic              skip_r, skip_nxt;
  logic [TL_W-1:0]   tl_r, tl_nxt;
  logic              pmatch_r, pmatch_nxt;
  logic              hmatch_r, hmatch_nxt;
  logic [LEN_W-1:0]  tnum_r, tnum_nxt;
  logic              dend_r, dend_nxt;
  logic [CODE_W-1:0] saved_r, saved_nxt;
  logic              code_ok_r, code_ok_nxt;
  logic [LEN_W-1:0]  remain_r, remain_nxt;
  logic              seen_r, seen_nxt;
  logic [LEN_W-1:0]  deflen_r;

  kind_t             kind_v;
  logic [7:0]        payload_v;
  logic [CODE_W-1:0] code_v;

  logic              out_valid_r;
  logic [2:0]        out_kind_r;
  logic [7:0]        out_payload_r;
  logic [CODE_W-1:0] out_code_r;

  assign cfg_ready        = 1'b1;
  assign pop              = item_valid && (!out_valid_r || out_ready);
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_payload_byte = out_payload_r;
  assign out_status_code  = out_code_r;

  // Next state and result for the item at the head of the queue
  always_comb begin
    logic            delim;
    logic            done_v;
    logic [LEN_W+3:0] prod;

    phase_nxt    = phase_r;
    crlf_nxt     = crlf_r;
    exp_code_nxt = exp_code_r;
    exp_msg_nxt  = exp_msg_r;
    exp_len_nxt  = exp_len_r;
    skip_nxt     = skip_r;
    tl_nxt       = tl_r;
    pmatch_nxt   = pmatch_r;
    hmatch_nxt   = hmatch_r;
    tnum_nxt     = tnum_r;
    dend_nxt     = dend_r;
    saved_nxt    = saved_r;
    code_ok_nxt  = code_ok_r;
    remain_nxt   = remain_r;
    seen_nxt     = seen_r;
    kind_v       = KIND_NONE;
    payload_v    = '0;
    code_v       = '0;
    delim        = item.is_cr || item.is_lf || item.is_sp || item.is_nul;
    done_v       = 1'b0;
    prod         = '0;

    if (pop) begin
      unique case (item.mode)
        MODE_START: begin
          phase_nxt    = PH_HEADER;
          crlf_nxt     = '0;
          exp_code_nxt = 1'b0;
          exp_msg_nxt  = 1'b0;
          exp_len_nxt  = 1'b0;
          skip_nxt     = 1'b0;
          tl_nxt       = '0;
          pmatch_nxt   = 1'b1;
          hmatch_nxt   = 1'b1;
          tnum_nxt     = '0;
          dend_nxt     = 1'b0;
          saved_nxt    = '0;
          code_ok_nxt  = 1'b0;
          remain_nxt   = deflen_r;
          seen_nxt     = 1'b0;
        end
        MODE_CLOSE: begin
          if (phase_r == PH_HEADER || phase_r == PH_BODY) begin
            kind_v    = KIND_FINISHED;
            phase_nxt = PH_DONE;
          end
        end
        MODE_DATA: begin
          unique case (phase_r)
            PH_HEADER: begin
              // message text after a space is skipped to line end
              if (skip_r) begin
                if (!item.is_cr && !item.is_lf) begin
                  done_v = 1'b1;
                end else begin
                  skip_nxt = 1'b0;
                end
              end
              // token end
              if (!done_v && delim) begin
                if (pmatch_r && tl_r >= HTTP_TAG_LEN) begin
                  exp_code_nxt = 1'b1;
                end else if (exp_code_r) begin
                  saved_nxt    = (tnum_r > {{(LEN_W-CODE_W){1'b0}}, CODE_MAX}) ?
                                 CODE_MAX : tnum_r[CODE_W-1:0];
                  code_ok_nxt  = !dend_r && tl_r == CODE_LEN &&
                                 tnum_r == {{(LEN_W-10){1'b0}}, CODE_OK};
                  exp_code_nxt = 1'b0;
                  exp_msg_nxt  = 1'b1;
                end else if (exp_msg_r) begin
                  exp_msg_nxt = 1'b0;
                  code_v      = saved_r;
                  if (!code_ok_r) begin
                    phase_nxt = PH_DONE;
                    kind_v    = KIND_REJECT;
                    done_v    = 1'b1;
                  end else begin
                    seen_nxt = 1'b1;
                    kind_v   = KIND_ACCEPT;
                    if (item.is_sp || item.is_nul) begin
                      skip_nxt = 1'b1;
                      done_v   = 1'b1;
                    end
                  end
                end else if (exp_len_r) begin
                  remain_nxt  = tnum_r;
                  exp_len_nxt = 1'b0;
                end else if (hmatch_r && tl_r == CLEN_TAG_LEN) begin
                  exp_len_nxt = 1'b1;
                end
                tl_nxt     = '0;
                pmatch_nxt = 1'b1;
                hmatch_nxt = 1'b1;
                tnum_nxt   = '0;
                dend_nxt   = 1'b0;
              end
              // CR LF CR LF tracking and token accumulation
              if (!done_v) begin
                if (item.is_cr) begin
                  crlf_nxt = (crlf_r == 2'd2) ? 2'd3 : 2'd1;
                end else if (item.is_lf) begin
                  if (crlf_r == 2'd1) begin
                    crlf_nxt = 2'd2;
                  end else if (crlf_r == 2'd3) begin
                    crlf_nxt  = 2'd0;
                    phase_nxt = PH_BODY;
                  end else begin
                    crlf_nxt = 2'd0;
                  end
                end else if (!item.is_sp) begin
                  crlf_nxt = 2'd0;
                  if (tl_nxt < HTTP_TAG_LEN && item.data != TAG_HTTP[tl_nxt[2:0]]) begin
                    pmatch_nxt = 1'b0;
                  end
                  if (tl_nxt < CLEN_TAG_LEN) begin
                    if (item.data != TAG_CLEN[tl_nxt[3:0]]) begin
                      hmatch_nxt = 1'b0;
                    end
                  end else begin
                    hmatch_nxt = 1'b0;
                  end
                  if (!dend_nxt) begin
                    if (item.is_digit) begin
                      // n*10 + d as two shifts and adds, then saturate
                      prod = {tnum_nxt, 3'b000} + {2'b00, tnum_nxt, 1'b0}
                             + {{LEN_W{1'b0}}, item.digit};
                      tnum_nxt = (prod > {4'b0000, LEN_MAX}) ? LEN_MAX : prod[LEN_W-1:0];
                    end else begin
                      dend_nxt = 1'b1;
                    end
                  end
                  if (tl_nxt < TL_MAX) begin
                    tl_nxt = tl_nxt + 1'b1;
                  end
                end
              end
            end
            PH_BODY: begin
              if (remain_r != '0) begin
                remain_nxt = remain_r - 1'b1;
                if (seen_r) begin
                  kind_v    = KIND_PAYLOAD;
                  payload_v = item.data;
                end
              end else begin
                kind_v    = KIND_FINISHED;
                phase_nxt = PH_DONE;
              end
            end
            default: begin
              kind_v = KIND_NONE;
            end
          endcase
        end
        default: begin
          kind_v = KIND_NONE;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      crlf_r     <= '0;
      exp_code_r <= 1'b0;
      exp_msg_r  <= 1'b0;
      exp_len_r  <= 1'b0;
      skip_r     <= 1'b0;
      tl_r       <= '0;
      pmatch_r   <= 1'b1;
      hmatch_r   <= 1'b1;
      tnum_r     <= '0;
      dend_r     <= 1'b0;
      saved_r    <= '0;
      code_ok_r  <= 1'b0;
      remain_r   <= RESET_LENGTH;
      seen_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      crlf_r     <= crlf_nxt;
      exp_code_r <= exp_code_nxt;
      exp_msg_r  <= exp_msg_nxt;
      exp_len_r  <= exp_len_nxt;
      skip_r     <= skip_nxt;
      tl_r       <= tl_nxt;
      pmatch_r   <= pmatch_nxt;
      hmatch_r   <= hmatch_nxt;
      tnum_r     <= tnum_nxt;
      dend_r     <= dend_nxt;
      saved_r    <= saved_nxt;
      code_ok_r  <= code_ok_nxt;
      remain_r   <= remain_nxt;
      seen_r     <= seen_nxt;
    end
  end

  // Default body length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deflen_r <= RESET_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      deflen_r <= cfg_default_length;
    end
  end

  // Output register: valid is control, payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind_r    <= kind_v;
      out_payload_r <= payload_v;
      out_code_r    <= code_v;
    end
  end

endmodule

/* hw/rtl/http_response_header_parser.sv */
// HTTP response header parser, one byte per transfer.
// Channels: in_* (valid/ready) carries mode and data_byte; out_* (valid/ready)
// carries kind, payload_byte and status_code; cfg_* (valid/ready) writes the
// default body length, used when no Content-Length header is present.
// Every input transfer yields exactly one output transfer, in order
// (kind 0 means nothing to report for that byte).
// An input byte passes through the queue and then the back end's output
// register before its result appears on out_*.
// Throughput: one byte per clock while the receiver keeps out_ready high;
// the back end takes one queued item per cycle when its output is free.
// The front end classifies bytes into a FIFO_DEPTH entry queue; when the
// receiver stalls, the output register holds, the back end stops, the
// queue fills and in_ready drops once it is full.
// Reset (rst_n low, synchronous) empties the queue and output register,
// returns the parser to the header phase and sets the default length and
// the current body length to 1000000000. cfg_ready is always high; a write
// takes effect at the next start-of-response item.
// Depends on hrhp_pkg, hrhp_front, hrhp_fifo, hrhp_back.
`include "http_response_header_parser_assert.svh"

module http_response_header_parser import hrhp_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [7:0]        out_payload_byte,
  output logic [CODE_W-1:0] out_status_code,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_default_length
);

  item_t front_item;
  item_t head_item;
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;
  logic  q_push;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Classify incoming bytes
  hrhp_front u_front (
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .item         (front_item)
  );

  // Decoupling queue
  hrhp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .pop_item  (head_item),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Parser state machine and output register
  hrhp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (q_not_empty),
    .item               (head_item),
    .pop                (q_pop),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_default_length (cfg_default_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_status_code    (out_status_code)
  );

  // Checks
  `HRHP_CHECK_NOW(a_payload_only_for_body, out_valid && out_kind != KIND_PAYLOAD, out_payload_byte == 8'd0, "payload byte set on a non-body result")
  `HRHP_CHECK_NOW(a_code_only_for_status, out_valid && out_kind != KIND_ACCEPT && out_kind != KIND_REJECT, out_status_code == '0, "status code set on a non-status result")
  `HRHP_CHECK_NOW(a_code_saturated, out_valid, out_status_code <= CODE_MAX, "status code above saturation limit")
  `HRHP_CHECK_NEXT(a_queue_drains, q_not_empty && !out_valid, out_valid, "queued item not taken by back end")

endmodule
